@@ design/sm3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sm3_pkg;

   typedef logic [31:0] word_type;
   typedef logic [2:0]  count_type;
   typedef logic [2:0]  index_type;
   typedef logic [5:0]  round_type;

   localparam word_type T_LOW  = 32'h79cc4519;
   localparam word_type T_HIGH = 32'h7a879d8a;
   localparam word_type PAD    = 32'h80000000;

   localparam count_type FULL_BYTES = 3'd4;

   localparam word_type IV [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   function automatic word_type rotl32(word_type x, logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

   function automatic word_type perm0(word_type x);
      return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
   endfunction

   function automatic word_type perm1(word_type x);
      return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
   endfunction

   // round constant already rotated by j mod 32
   function automatic word_type t_rot(round_type j);
      word_type t;
      t = (j < 6'd16) ? T_LOW : T_HIGH;
      return rotl32(t, j[4:0]);
   endfunction

endpackage

`default_nettype wire

@@ design/sm3_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sm3_req_if;
   import sm3_pkg::*;

   logic      valid;
   logic      ready;
   word_type  message_word;
   count_type byte_count;
   logic      last_word;

   modport source (output valid, message_word, byte_count, last_word, input ready);
   modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface sm3_rsp_if;
   import sm3_pkg::*;

   logic      valid;
   logic      ready;
   word_type  digest_word;
   index_type word_index;
   logic      last_of_digest;

   modport source (output valid, digest_word, word_index, last_of_digest, input ready);
   modport sink   (input valid, digest_word, word_index, last_of_digest, output ready);
endinterface

`default_nettype wire

@@ design/sm3_hash_engine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat
// req_bus   in   message_word[31:0], byte_count[2:0], last_word
// rsp_bus   out  digest_word[31:0], word_index[2:0], last_of_digest
//
// A word that does not complete a block is only shifted in; one that completes it
// also starts a compression, one round of the shared round unit per cycle.
// A last word adds padding and length fill words and one or two compressions,
// then 8 digest beats; req_bus.ready stays low throughout.
// Digest beats hold while rsp_bus.ready is low. Synchronous reset loads the
// initial value and clears the length and word position.

module sm3_hash_engine_core (
   input  wire logic  clock,
   input  wire logic  reset,
   sm3_req_if.sink    req_bus,
   sm3_rsp_if.source  rsp_bus
);
   import sm3_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_RUN, ST_OUT} state_type;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   word_type    cv_ff [8];
   word_type    cv_in [8];
   word_type    v_ff [8];
   word_type    v_in [8];
   word_type    w_ff [16];
   word_type    w_in [16];
   logic [63:0] len_ff, len_in;
   logic [3:0]  pos_ff, pos_in;
   round_type   round_ff, round_in;
   index_type   idx_ff, idx_in;
   logic        pad_pend_ff, pad_pend_in;
   logic        len_ok_ff, len_ok_in;
   word_type    pad_word_ff, pad_word_in;

   logic        load_en;
   logic        shift_en;
   word_type    shift_word;
   count_type   count_sat;
   word_type    masked;
   word_type    w_new;
   word_type    a12, ss1, ss2, tt1, tt2, bool_f, bool_g;

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = (state_ff == ST_OUT);
   assign rsp_bus.digest_word    = cv_ff[idx_ff];
   assign rsp_bus.word_index     = idx_ff;
   assign rsp_bus.last_of_digest = (idx_ff == 3'd7);

   always_comb begin
      count_sat = (req_bus.byte_count > FULL_BYTES) ? FULL_BYTES : req_bus.byte_count;
      case (count_sat)
         3'd1:    masked = {req_bus.message_word[31:24], 24'h800000};
         3'd2:    masked = {req_bus.message_word[31:16], 16'h8000};
         3'd3:    masked = {req_bus.message_word[31:8], 8'h80};
         default: masked = PAD;
      endcase
   end

   // round unit
   always_comb begin
      w_new = perm1(w_ff[0] ^ w_ff[7] ^ rotl32(w_ff[13], 5'd15))
              ^ rotl32(w_ff[3], 5'd7) ^ w_ff[10];
      if (round_ff < 6'd16) begin
         bool_f = v_ff[0] ^ v_ff[1] ^ v_ff[2];
         bool_g = v_ff[4] ^ v_ff[5] ^ v_ff[6];
      end else begin
         bool_f = (v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]);
         bool_g = (v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]);
      end
      a12 = rotl32(v_ff[0], 5'd12);
      ss1 = rotl32(a12 + v_ff[4] + t_rot(round_ff), 5'd7);
      ss2 = ss1 ^ a12;
      tt1 = bool_f + v_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = bool_g + v_ff[7] + ss1 + w_ff[0];
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      cv_in       = cv_ff;
      v_in        = v_ff;
      w_in        = w_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      round_in    = round_ff;
      idx_in      = idx_ff;
      pad_pend_in = pad_pend_ff;
      len_ok_in   = len_ok_ff;
      pad_word_in = pad_word_ff;
      load_en     = 1'b0;
      shift_en    = 1'b0;
      shift_word  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (!req_bus.last_word) begin
                  len_in     = len_ff + 64'd32;
                  load_en    = 1'b1;
                  shift_word = req_bus.message_word;
                  ret_in     = ST_IDLE;
               end else begin
                  len_in      = len_ff + {58'd0, count_sat, 3'd0};
                  pad_pend_in = 1'b1;
                  state_in    = ST_FILL;
                  ret_in      = ST_FILL;
                  if (count_sat == FULL_BYTES) begin
                     load_en     = 1'b1;
                     shift_word  = req_bus.message_word;
                     pad_word_in = PAD;
                  end else begin
                     pad_word_in = masked;
                  end
               end
            end
         end
         ST_FILL: begin
            load_en = 1'b1;
            ret_in  = ST_FILL;
            if (pad_pend_ff) begin
               shift_word  = pad_word_ff;
               pad_pend_in = 1'b0;
               len_ok_in   = (pos_ff <= 4'd13);
            end else if (len_ok_ff && pos_ff == 4'd14) begin
               shift_word = len_ff[63:32];
            end else if (len_ok_ff && pos_ff == 4'd15) begin
               shift_word = len_ff[31:0];
               ret_in     = ST_OUT;
            end else begin
               shift_word = '0;
            end
            // a block closed here without the length leaves room for it in the next
            if (pos_ff == 4'd15 && !(len_ok_ff && !pad_pend_ff)) begin
               len_ok_in = 1'b1;
            end
         end
         ST_RUN: begin
            shift_en   = 1'b1;
            shift_word = w_new;
            round_in   = round_ff + 6'd1;
            v_in[0] = tt1;
            v_in[1] = v_ff[0];
            v_in[2] = rotl32(v_ff[1], 5'd9);
            v_in[3] = v_ff[2];
            v_in[4] = perm0(tt2);
            v_in[5] = v_ff[4];
            v_in[6] = rotl32(v_ff[5], 5'd19);
            v_in[7] = v_ff[6];
            if (round_ff == 6'd63) begin
               for (int k = 0; k < 8; k++) begin
                  cv_in[k] = cv_ff[k] ^ v_in[k];
               end
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cv_in    = IV;
                  len_in   = '0;
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load_en) begin
         shift_en = 1'b1;
         pos_in   = pos_ff + 4'd1;
         if (pos_ff == 4'd15) begin
            state_in = ST_RUN;
            round_in = '0;
            v_in     = cv_ff;
         end
      end

      if (shift_en) begin
         for (int k = 0; k < 15; k++) begin
            w_in[k] = w_ff[k + 1];
         end
         w_in[15] = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ret_ff      <= ST_IDLE;
         cv_ff       <= IV;
         len_ff      <= '0;
         pos_ff      <= '0;
         round_ff    <= '0;
         idx_ff      <= '0;
         pad_pend_ff <= 1'b0;
         len_ok_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         cv_ff       <= cv_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
         round_ff    <= round_in;
         idx_ff      <= idx_in;
         pad_pend_ff <= pad_pend_in;
         len_ok_ff   <= len_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      w_ff        <= w_in;
      pad_word_ff <= pad_word_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("input taken while digest pending");

   a_run_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && $past(state_ff) != ST_RUN) |-> round_ff == 6'd0)
      else $error("compression entered mid-round");

   a_out_block_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (pos_ff == 4'd0 && !pad_pend_ff))
      else $error("digest emitted with a partial block");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last_of_digest)
      |=> (req_bus.ready && len_ff == 64'd0))
      else $error("no return to initial state after digest");

endmodule

`default_nettype wire
